FILE: rtl/pidbc_pkg.sv
// ----------------------------------------------------------------------------
// pidbc_pkg
// Shared types and constants for the back-calculation anti-windup PID core:
// fixed-point limits, register indexes, sequencer states and command bundles.
// ----------------------------------------------------------------------------
package pidbc_pkg;

   // Internal arithmetic is carried in 64-bit signed words.
   localparam int CALC_W  = 64;
   // Magnitude of a multiplier operand and of a gain.
   localparam int MAG_W   = 63;
   localparam int GAIN_W  = 24;
   localparam int ALPHA_W = 17;
   // Multiplier operand split: low half width.
   localparam int LO_W    = 32;
   // Fraction bits of the Q.16 gains.
   localparam int FRAC_W  = 16;
   // Saturated product magnitude holds up to 2^61.
   localparam int RES_W   = 62;

   // Saturation bounds of every intermediate sum and product.
   localparam logic [RES_W-1:0]         SAT_MAG = 62'h2000_0000_0000_0000;
   localparam logic signed [CALC_W-1:0] SAT_POS = 64'sh2000_0000_0000_0000;
   localparam logic signed [CALC_W-1:0] SAT_NEG = 64'shE000_0000_0000_0000;

   // Filter coefficient of one, which also bounds larger writes.
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P,
      CSR_GAIN_I_DT,
      CSR_GAIN_D_OVER_DT,
      CSR_GAIN_FF,
      CSR_GAIN_T_DT,
      CSR_LPF_ALPHA,
      CSR_OUT_MIN,
      CSR_OUT_MAX
   } csr_index_type;

   // Products formed on the shared multiplier, in the order they are run.
   typedef enum logic [2:0] {
      JOB_FILT,
      JOB_P,
      JOB_D,
      JOB_FF,
      JOB_I,
      JOB_T
   } job_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL_GO,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_FIN,
      ST_COMMIT,
      ST_CLAMP,
      ST_BACK,
      ST_INTEG,
      ST_EMIT
   } state_type;

   // Steps of one multiplication.
   typedef struct packed {
      logic load;
      logic lo;
      logic hi;
      logic fin;
   } mul_cmd_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        prep;
      mul_cmd_type mul;
      logic        commit;
      job_type     job;
      logic        clamp;
      logic        back;
      logic        integ;
      logic        emit;
   } cmd_type;

endpackage

FILE: rtl/pid_backcalc_antiwindup_core.sv
// ----------------------------------------------------------------------------
// pid_backcalc_antiwindup_core
// PID controller step with measurement-side filtered derivative, setpoint
// feed-forward, output limits and back-calculation anti-windup.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one sample (setpoint, measurement, signed Q16.16)
// per transfer; the rsp channel returns one result per sample: the limited
// drive and a flag that is set when the limits were applied.
// Gains, filter coefficient and limits are written through the csr port
// while no sample is in flight; a write takes effect on the next sample.
// A new sample is taken only after the step for the previous one has handed its
// result over. The six products of a step are formed one after another on the
// single 32x24 multiplier.
// The result sits in an output register, so the next sample is taken while
// an earlier result waits. If it still waits when the next step is done, that
// step waits for the output register and req_ready stays low meanwhile.
// Reset clears the integrator, filter and last measurement, marks the next
// sample as the first one (no derivative kick) and restores register defaults.
// ----------------------------------------------------------------------------
module pid_backcalc_antiwindup_core #(
   parameter  int DATA_WIDTH = 32,
   parameter  int ACC_WIDTH  = 48,
   localparam int CSR_W      = (DATA_WIDTH > pidbc_pkg::GAIN_W) ? DATA_WIDTH
                                                                : pidbc_pkg::GAIN_W
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [DATA_WIDTH-1:0]          req_setpoint,
   input  logic signed [DATA_WIDTH-1:0]          req_measurement,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [DATA_WIDTH-1:0]          rsp_drive,
   output logic                                  rsp_saturated,
   input  logic                                  csr_we,
   input  logic [pidbc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]                      csr_wdata
);

   pidbc_pkg::cmd_type cmd;

   // Step sequencer.
   pidbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Arithmetic, state and registers.
   pidbc_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .ACC_WIDTH  (ACC_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_setpoint    (req_setpoint),
      .req_measurement (req_measurement),
      .rsp_drive       (rsp_drive),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

FILE: rtl/pidbc_mul.sv
// ----------------------------------------------------------------------------
// pidbc_mul
// Sign-magnitude Q.16 scaling unit built on one 32x24 multiplier. A product
// takes four steps: load, low partial, high partial, shift and saturate.
// ----------------------------------------------------------------------------
module pidbc_mul (
   input  logic                                      clock,
   input  pidbc_pkg::mul_cmd_type                    cmd,
   input  logic signed [pidbc_pkg::CALC_W-1:0]       operand,
   input  logic        [pidbc_pkg::GAIN_W-1:0]       gain,
   output logic        [pidbc_pkg::RES_W-1:0]        res_mag,
   output logic                                      res_neg
);

   localparam int MAG_W  = pidbc_pkg::MAG_W;
   localparam int GAIN_W = pidbc_pkg::GAIN_W;
   localparam int LO_W   = pidbc_pkg::LO_W;
   localparam int HI_W   = MAG_W - LO_W;
   localparam int FULL_W = MAG_W + GAIN_W;
   localparam int SCL_W  = FULL_W - pidbc_pkg::FRAC_W;

   logic [MAG_W-1:0]          mag_ff;
   logic [MAG_W-1:0]          mag_in;
   logic                      neg_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic [LO_W+GAIN_W-1:0]    plo_ff;
   logic [HI_W+GAIN_W-1:0]    phi_ff;
   logic [FULL_W-1:0]         full;
   logic [SCL_W-1:0]          scaled;
   logic [pidbc_pkg::RES_W-1:0] res_ff;
   logic [pidbc_pkg::RES_W-1:0] res_in;

   // Magnitude of the operand; the sign is applied by the consumer.
   assign mag_in = operand[pidbc_pkg::CALC_W-1] ? MAG_W'(-operand) : MAG_W'(operand);

   // Recombine partial products, drop the fraction, saturate at 2^61.
   assign full   = {phi_ff, LO_W'(0)} + FULL_W'(plo_ff);
   assign scaled = full[FULL_W-1:pidbc_pkg::FRAC_W];
   assign res_in = (scaled > SCL_W'(pidbc_pkg::SAT_MAG)) ? pidbc_pkg::SAT_MAG
                                                        : pidbc_pkg::RES_W'(scaled);

   // Operand registers and partial products.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff  <= mag_in;
         neg_ff  <= operand[pidbc_pkg::CALC_W-1];
         gain_ff <= gain;
      end
      if (cmd.lo) begin
         plo_ff <= mag_ff[LO_W-1:0] * gain_ff;
      end
      if (cmd.hi) begin
         phi_ff <= mag_ff[MAG_W-1:LO_W] * gain_ff;
      end
      if (cmd.fin) begin
         res_ff <= res_in;
      end
   end

   assign res_mag = res_ff;
   assign res_neg = neg_ff;

endmodule

FILE: rtl/pidbc_datapath.sv
// ----------------------------------------------------------------------------
// pidbc_datapath
// Configuration registers, controller state (integrator, last measurement,
// filtered delta), the shared scaling unit and two saturating adders.
// ----------------------------------------------------------------------------
module pidbc_datapath #(
   parameter  int DATA_WIDTH = 32,
   parameter  int ACC_WIDTH  = 48,
   localparam int CSR_W      = (DATA_WIDTH > pidbc_pkg::GAIN_W) ? DATA_WIDTH
                                                                : pidbc_pkg::GAIN_W
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pidbc_pkg::cmd_type                    cmd,
   input  logic                                  csr_we,
   input  logic [pidbc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]                      csr_wdata,
   input  logic signed [DATA_WIDTH-1:0]          req_setpoint,
   input  logic signed [DATA_WIDTH-1:0]          req_measurement,
   output logic signed [DATA_WIDTH-1:0]          rsp_drive,
   output logic                                  rsp_saturated
);

   localparam int CALC_W  = pidbc_pkg::CALC_W;
   localparam int GAIN_W  = pidbc_pkg::GAIN_W;
   localparam int ALPHA_W = pidbc_pkg::ALPHA_W;
   localparam int ERR_W   = DATA_WIDTH + 1;
   localparam int FD_W    = DATA_WIDTH + 1;
   localparam int DIFF_W  = DATA_WIDTH + 2;
   localparam int ACC_SH  = (ACC_WIDTH - 1 > 61) ? 61 : ACC_WIDTH - 1;
   localparam logic signed [CALC_W-1:0] ACC_HI =
      (ACC_SH >= 61) ? pidbc_pkg::SAT_POS : ((64'sd1 <<< ACC_SH) - 64'sd1);
   localparam logic signed [CALC_W-1:0] ACC_LO = -(64'sd1 <<< ACC_SH);

   // Configuration.
   logic [GAIN_W-1:0]              gain_p_ff;
   logic [GAIN_W-1:0]              gain_i_ff;
   logic [GAIN_W-1:0]              gain_d_ff;
   logic [GAIN_W-1:0]              gain_fwd_ff;
   logic [GAIN_W-1:0]              gain_t_ff;
   logic [ALPHA_W-1:0]             alpha_ff;
   logic [ALPHA_W-1:0]             alpha_in;
   logic signed [DATA_WIDTH-1:0]   out_min_ff;
   logic signed [DATA_WIDTH-1:0]   out_max_ff;

   // Controller state.
   logic signed [ACC_WIDTH-1:0]    integ_ff;
   logic signed [ACC_WIDTH-1:0]    integ_in;
   logic signed [DATA_WIDTH-1:0]   last_ff;
   logic signed [FD_W-1:0]         fd_ff;
   logic                           first_ff;

   // Working registers of one step.
   logic signed [DATA_WIDTH-1:0]   sp_ff;
   logic signed [DATA_WIDTH-1:0]   ms_ff;
   logic signed [ERR_W-1:0]        err_ff;
   logic signed [ERR_W-1:0]        err_in;
   logic signed [DIFF_W-1:0]       diff_ff;
   logic signed [DIFF_W-1:0]       diff_in;
   logic signed [CALC_W-1:0]       acc_ff;
   logic signed [CALC_W-1:0]       trim_ff;
   logic signed [CALC_W-1:0]       back_ff;
   logic signed [CALC_W-1:0]       back_in;
   logic signed [DATA_WIDTH-1:0]   clamped_ff;
   logic signed [DATA_WIDTH-1:0]   clamped_in;
   logic                           sat_ff;
   logic                           sat_in;
   logic signed [DATA_WIDTH-1:0]   rsp_drive_ff;
   logic                           rsp_sat_ff;

   // Combinational intermediates.
   logic signed [DATA_WIDTH-1:0]   last_eff;
   logic signed [ERR_W-1:0]        nd;
   logic signed [CALC_W-1:0]       mul_operand;
   logic        [GAIN_W-1:0]       mul_gain;
   logic        [pidbc_pkg::RES_W-1:0] res_mag;
   logic                           res_neg;
   logic signed [CALC_W-1:0]       base;
   logic signed [CALC_W-1:0]       term;
   logic signed [CALC_W-1:0]       raw;
   logic signed [CALC_W-1:0]       commit_val;
   logic                           below;
   logic                           above;
   logic signed [CALC_W-1:0]       back_raw;
   logic signed [CALC_W-1:0]       integ_ext;
   logic signed [CALC_W-1:0]       isum;

   // Configuration writes; alpha above one is held at one.
   assign alpha_in = (csr_wdata[ALPHA_W-1:0] > pidbc_pkg::ALPHA_ONE) ? pidbc_pkg::ALPHA_ONE
                                                                    : csr_wdata[ALPHA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
         gain_fwd_ff <= '0;
         gain_t_ff   <= '0;
         alpha_ff    <= pidbc_pkg::ALPHA_ONE;
         out_min_ff  <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
         out_max_ff  <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else if (csr_we) begin
         case (pidbc_pkg::csr_index_type'(csr_index))
            pidbc_pkg::CSR_GAIN_P:         gain_p_ff   <= csr_wdata[GAIN_W-1:0];
            pidbc_pkg::CSR_GAIN_I_DT:      gain_i_ff   <= csr_wdata[GAIN_W-1:0];
            pidbc_pkg::CSR_GAIN_D_OVER_DT: gain_d_ff   <= csr_wdata[GAIN_W-1:0];
            pidbc_pkg::CSR_GAIN_FF:        gain_fwd_ff <= csr_wdata[GAIN_W-1:0];
            pidbc_pkg::CSR_GAIN_T_DT:      gain_t_ff   <= csr_wdata[GAIN_W-1:0];
            pidbc_pkg::CSR_LPF_ALPHA:      alpha_ff    <= alpha_in;
            pidbc_pkg::CSR_OUT_MIN:        out_min_ff  <= csr_wdata[DATA_WIDTH-1:0];
            pidbc_pkg::CSR_OUT_MAX:        out_max_ff  <= csr_wdata[DATA_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Error and measurement change. The first sample sees no change.
   assign last_eff = first_ff ? ms_ff : last_ff;
   assign err_in   = ERR_W'(sp_ff) - ERR_W'(ms_ff);
   assign nd       = ERR_W'(last_eff) - ERR_W'(ms_ff);
   assign diff_in  = DIFF_W'(nd) - DIFF_W'(fd_ff);

   // Operand and gain selection for the shared scaling unit.
   always_comb begin
      case (cmd.job)
         pidbc_pkg::JOB_FILT: begin
            mul_operand = CALC_W'(diff_ff);
            mul_gain    = GAIN_W'(alpha_ff);
         end
         pidbc_pkg::JOB_P: begin
            mul_operand = CALC_W'(err_ff);
            mul_gain    = gain_p_ff;
         end
         pidbc_pkg::JOB_D: begin
            mul_operand = CALC_W'(fd_ff);
            mul_gain    = gain_d_ff;
         end
         pidbc_pkg::JOB_FF: begin
            mul_operand = CALC_W'(sp_ff);
            mul_gain    = gain_fwd_ff;
         end
         pidbc_pkg::JOB_I: begin
            mul_operand = CALC_W'(err_ff);
            mul_gain    = gain_i_ff;
         end
         pidbc_pkg::JOB_T: begin
            mul_operand = back_ff;
            mul_gain    = gain_t_ff;
         end
         default: begin
            mul_operand = '0;
            mul_gain    = '0;
         end
      endcase
   end

   pidbc_mul u_mul (
      .clock   (clock),
      .cmd     (cmd.mul),
      .operand (mul_operand),
      .gain    (mul_gain),
      .res_mag (res_mag),
      .res_neg (res_neg)
   );

   // Saturating accumulate of a finished product onto the term it feeds.
   always_comb begin
      case (cmd.job)
         pidbc_pkg::JOB_FILT: base = CALC_W'(fd_ff);
         pidbc_pkg::JOB_P:    base = CALC_W'(integ_ff);
         pidbc_pkg::JOB_D:    base = acc_ff;
         pidbc_pkg::JOB_FF:   base = acc_ff;
         pidbc_pkg::JOB_I:    base = '0;
         pidbc_pkg::JOB_T:    base = trim_ff;
         default:             base = '0;
      endcase
   end

   assign term       = signed'(CALC_W'(res_mag));
   assign raw        = res_neg ? (base - term) : (base + term);
   assign commit_val = (raw > pidbc_pkg::SAT_POS) ? pidbc_pkg::SAT_POS :
                       (raw < pidbc_pkg::SAT_NEG) ? pidbc_pkg::SAT_NEG : raw;

   // Output limits; the lower limit wins when a value is below it and above the upper one.
   assign below      = acc_ff < CALC_W'(out_min_ff);
   assign above      = acc_ff > CALC_W'(out_max_ff);
   assign clamped_in = below ? out_min_ff : (above ? out_max_ff : DATA_WIDTH'(acc_ff));
   assign sat_in     = below || above;

   // Back-calculation term, dropped unless it pulls the integrator toward zero.
   assign integ_ext = CALC_W'(integ_ff);
   assign back_raw  = CALC_W'(clamped_ff) - acc_ff;
   assign back_in   = ((back_raw > 64'sd0) == (integ_ext > 64'sd0)) ? '0 : back_raw;

   // Integrator update, saturated at its own width.
   assign isum     = integ_ext + trim_ff;
   assign integ_in = ACC_WIDTH'((isum > ACC_HI) ? ACC_HI : ((isum < ACC_LO) ? ACC_LO : isum));

   // Controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
         fd_ff    <= '0;
         first_ff <= 1'b1;
      end else begin
         if (cmd.prep) begin
            last_ff  <= ms_ff;
            first_ff <= 1'b0;
         end
         if (cmd.commit && (cmd.job == pidbc_pkg::JOB_FILT)) begin
            fd_ff <= FD_W'(commit_val);
         end
         if (cmd.integ) begin
            integ_ff <= integ_in;
         end
      end
   end

   // Working registers and the result register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sp_ff <= req_setpoint;
         ms_ff <= req_measurement;
      end
      if (cmd.prep) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
      end
      if (cmd.commit) begin
         case (cmd.job)
            pidbc_pkg::JOB_P:  acc_ff  <= commit_val;
            pidbc_pkg::JOB_D:  acc_ff  <= commit_val;
            pidbc_pkg::JOB_FF: acc_ff  <= commit_val;
            pidbc_pkg::JOB_I:  trim_ff <= commit_val;
            pidbc_pkg::JOB_T:  trim_ff <= commit_val;
            default: ;
         endcase
      end
      if (cmd.clamp) begin
         clamped_ff <= clamped_in;
         sat_ff     <= sat_in;
      end
      if (cmd.back) begin
         back_ff <= back_in;
      end
      if (cmd.emit) begin
         rsp_drive_ff <= clamped_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

   assign rsp_drive     = rsp_drive_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

FILE: rtl/pidbc_ctrl.sv
// ----------------------------------------------------------------------------
// pidbc_ctrl
// Sequencer for one control step: operand preparation, six products on the
// shared scaling unit, output limiting, integrator update and result handoff.
// ----------------------------------------------------------------------------
module pidbc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pidbc_pkg::cmd_type  cmd
);

   pidbc_pkg::state_type state_ff;
   pidbc_pkg::state_type state_in;
   pidbc_pkg::job_type   job_ff;
   pidbc_pkg::job_type   job_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   // State, current product and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidbc_pkg::ST_IDLE;
         job_ff       <= pidbc_pkg::JOB_FILT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cmd       = '0;
      cmd.job   = job_ff;
      req_ready = 1'b0;

      case (state_ff)
         pidbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = pidbc_pkg::ST_PREP;
            end
         end
         pidbc_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            job_in   = pidbc_pkg::JOB_FILT;
            state_in = pidbc_pkg::ST_MUL_GO;
         end
         pidbc_pkg::ST_MUL_GO: begin
            cmd.mul.load = 1'b1;
            state_in     = pidbc_pkg::ST_MUL_LO;
         end
         pidbc_pkg::ST_MUL_LO: begin
            cmd.mul.lo = 1'b1;
            state_in   = pidbc_pkg::ST_MUL_HI;
         end
         pidbc_pkg::ST_MUL_HI: begin
            cmd.mul.hi = 1'b1;
            state_in   = pidbc_pkg::ST_MUL_FIN;
         end
         pidbc_pkg::ST_MUL_FIN: begin
            cmd.mul.fin = 1'b1;
            state_in    = pidbc_pkg::ST_COMMIT;
         end
         pidbc_pkg::ST_COMMIT: begin
            // Fold the product in, then pick the next product or step.
            cmd.commit = 1'b1;
            case (job_ff)
               pidbc_pkg::JOB_FILT: begin
                  job_in   = pidbc_pkg::JOB_P;
                  state_in = pidbc_pkg::ST_MUL_GO;
               end
               pidbc_pkg::JOB_P: begin
                  job_in   = pidbc_pkg::JOB_D;
                  state_in = pidbc_pkg::ST_MUL_GO;
               end
               pidbc_pkg::JOB_D: begin
                  job_in   = pidbc_pkg::JOB_FF;
                  state_in = pidbc_pkg::ST_MUL_GO;
               end
               pidbc_pkg::JOB_FF: begin
                  state_in = pidbc_pkg::ST_CLAMP;
               end
               pidbc_pkg::JOB_I: begin
                  job_in   = pidbc_pkg::JOB_T;
                  state_in = pidbc_pkg::ST_MUL_GO;
               end
               pidbc_pkg::JOB_T: begin
                  state_in = pidbc_pkg::ST_INTEG;
               end
               default: begin
                  state_in = pidbc_pkg::ST_IDLE;
               end
            endcase
         end
         pidbc_pkg::ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = pidbc_pkg::ST_BACK;
         end
         pidbc_pkg::ST_BACK: begin
            cmd.back = 1'b1;
            job_in   = pidbc_pkg::JOB_I;
            state_in = pidbc_pkg::ST_MUL_GO;
         end
         pidbc_pkg::ST_INTEG: begin
            cmd.integ = 1'b1;
            state_in  = pidbc_pkg::ST_EMIT;
         end
         pidbc_pkg::ST_EMIT: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = pidbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pidbc_pkg::ST_IDLE;
         end
      endcase

      // The output register stays full until its transfer.
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/pidbc_checker.sv
// ----------------------------------------------------------------------------
// pidbc_checker
// Port-level checks for the PID core: result hold under stall, one sample
// in flight, reset state and fixed step latency.
// ----------------------------------------------------------------------------
module pidbc_checker #(
   parameter  int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [DATA_WIDTH-1:0]          rsp_drive,
   input  logic                                  rsp_saturated
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_saturated))
      else $error("result changed while stalled");

   // Only one sample is in flight: ready drops after each transfer.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while a step is running");

   // Reset empties the output and opens the input.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

   // A result that finds the output empty shows up a fixed time after its sample.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 36))
      else $error("result without matching sample transfer");

endmodule

bind pid_backcalc_antiwindup_core pidbc_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_pidbc_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the back-calculation anti-windup PID core. A short
// table of samples and register writes comes first, then randomized phases
// under several gain and limit settings. Every drive and saturated flag is
// checked against a typed value or a cycle-free software copy of the control law.
// ----------------------------------------------------------------------------
module tb;

   localparam int          PHASES        = 8;
   localparam int          PHASE_ITEMS   = 220;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          TAIL_CYCLES   = 40;
   localparam int          RUN_LIMIT_NS  = 10_000_000;
   localparam int          ACC_BITS      = 48;
   localparam longint      SAT_BOUND     = 64'sh2000_0000_0000_0000;
   localparam longint unsigned SAT_MAG_U = 64'h2000_0000_0000_0000;
   localparam longint      ACC_HI        = (64'sd1 <<< (ACC_BITS - 1)) - 1;
   localparam longint      ACC_LO        = -(64'sd1 <<< (ACC_BITS - 1));

   typedef struct packed {
      logic [31:0] drive;
      logic        limited;
   } drive_result_type;

   // One line of the directed table: either a register write or a sample.
   typedef struct {
      bit                       is_cfg;
      pidbc_pkg::csr_index_type reg_idx;
      logic [31:0]              reg_val;
      logic [31:0]              sp;
      logic [31:0]              ms;
      bit                       typed;
      logic [31:0]              drive;
      bit                       limited;
   } script_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_setpoint = '0;
   logic signed [31:0] req_measurement = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_drive;
   logic               rsp_saturated;
   logic               csr_we = 1'b0;
   logic [pidbc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // Expectation typed into the table, carried along with the payload.
   bit                 cur_typed = 1'b0;
   logic [31:0]        cur_drive = '0;
   bit                 cur_limited = 1'b0;

   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 hold_ticket = 0;
   int                 hold_served = 0;
   int                 hold_left = 0;

   int                 accepted_count = 0;
   int                 checked_count = 0;
   int                 limited_count = 0;
   int                 settings_count = 0;
   int                 error_count = 0;

   drive_result_type   awaited_results[$];
   script_row_type     script[$];

   // Controller copy: configuration and loop state.
   longint unsigned    kp, ki_dt, kd_dt, kff, kt_dt, alpha_q16;
   longint             lim_lo, lim_hi;
   longint             integ_acc, prev_meas, filt_delta;
   bit                 seed_pending;

   pid_backcalc_antiwindup_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_setpoint    (req_setpoint),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive       (rsp_drive),
      .rsp_saturated   (rsp_saturated),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // Every sum and product is held within +-2^61.
   function automatic longint limit61(longint x);
      if (x > SAT_BOUND) return SAT_BOUND;
      if (x < -SAT_BOUND) return -SAT_BOUND;
      return x;
   endfunction

   // Product with a Q.16 gain, magnitude truncated toward zero.
   function automatic longint scale_q16(longint a, longint unsigned g);
      longint unsigned mag, q, r, res;
      mag = (a < 0) ? -a : a;
      q = mag >> 16;
      r = mag & 64'hFFFF;
      if (g != 0 && q > SAT_MAG_U / g) begin
         res = SAT_MAG_U;
      end else begin
         res = q * g + ((r * g) >> 16);
         if (res > SAT_MAG_U) res = SAT_MAG_U;
      end
      return (a < 0) ? -longint'(res) : longint'(res);
   endfunction

   // One control step: updates the loop state and returns the limited drive.
   task automatic compute_drive(input logic signed [31:0] sp_in, ms_in,
                                output logic [31:0] drive, output bit limited);
      longint sp, ms, err, nd, p_term, d_term, ff_term, sum, clamped, back;
      sp = sp_in;
      ms = ms_in;
      err = sp - ms;
      // The first sample seeds the last measurement, so no derivative kick.
      if (seed_pending) begin
         prev_meas = ms;
         seed_pending = 1'b0;
      end
      nd = prev_meas - ms;
      prev_meas = ms;
      filt_delta = filt_delta + scale_q16(nd - filt_delta, alpha_q16);
      p_term = scale_q16(err, kp);
      d_term = scale_q16(filt_delta, kd_dt);
      ff_term = scale_q16(sp, kff);
      sum = limit61(limit61(limit61(p_term + integ_acc) + d_term) + ff_term);
      // The lower limit wins when the sum is below it and above the upper one.
      if (sum < lim_lo) clamped = lim_lo;
      else if (sum > lim_hi) clamped = lim_hi;
      else clamped = sum;
      // Back-calculation may only pull the integrator toward zero.
      back = clamped - sum;
      if ((back > 0) == (integ_acc > 0)) back = 0;
      integ_acc = limit61(integ_acc + limit61(scale_q16(err, ki_dt) + scale_q16(back, kt_dt)));
      if (integ_acc > ACC_HI) integ_acc = ACC_HI;
      else if (integ_acc < ACC_LO) integ_acc = ACC_LO;
      drive = clamped[31:0];
      limited = (clamped != sum);
   endtask

   // Mirror of the block: register writes, result checks and predictions.
   always @(posedge clock) begin : monitor
      drive_result_type want;
      logic [31:0]      pd;
      bit               pl;
      if (reset) begin
         kp = 0; ki_dt = 0; kd_dt = 0; kff = 0; kt_dt = 0;
         alpha_q16 = pidbc_pkg::ALPHA_ONE;
         lim_lo = -(64'sd1 <<< 31);
         lim_hi = (64'sd1 <<< 31) - 1;
         integ_acc = 0; prev_meas = 0; filt_delta = 0;
         seed_pending = 1'b1;
      end else begin
         if (csr_we) begin
            case (pidbc_pkg::csr_index_type'(csr_index))
               pidbc_pkg::CSR_GAIN_P:         kp = csr_wdata[pidbc_pkg::GAIN_W-1:0];
               pidbc_pkg::CSR_GAIN_I_DT:      ki_dt = csr_wdata[pidbc_pkg::GAIN_W-1:0];
               pidbc_pkg::CSR_GAIN_D_OVER_DT: kd_dt = csr_wdata[pidbc_pkg::GAIN_W-1:0];
               pidbc_pkg::CSR_GAIN_FF:        kff = csr_wdata[pidbc_pkg::GAIN_W-1:0];
               pidbc_pkg::CSR_GAIN_T_DT:      kt_dt = csr_wdata[pidbc_pkg::GAIN_W-1:0];
               pidbc_pkg::CSR_LPF_ALPHA: begin
                  alpha_q16 = (csr_wdata[pidbc_pkg::ALPHA_W-1:0] > pidbc_pkg::ALPHA_ONE)
                              ? pidbc_pkg::ALPHA_ONE : csr_wdata[pidbc_pkg::ALPHA_W-1:0];
               end
               pidbc_pkg::CSR_OUT_MIN:        lim_lo = longint'($signed(csr_wdata));
               pidbc_pkg::CSR_OUT_MAX:        lim_hi = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (rsp_saturated) limited_count++;
            if (awaited_results.size() == 0) begin
               error_count++;
               $error("result transfer with nothing awaited");
            end else begin
               want = awaited_results.pop_front();
               if (rsp_drive !== want.drive) begin
                  error_count++;
                  $error("drive: expected %0d, got %0d", $signed(want.drive), rsp_drive);
               end
               if (rsp_saturated !== want.limited) begin
                  error_count++;
                  $error("saturated: expected %0d, got %0d", want.limited, rsp_saturated);
               end
            end
         end
         if (req_valid && req_ready) begin
            compute_drive(req_setpoint, req_measurement, pd, pl);
            if (cur_typed) awaited_results.push_back('{cur_drive, cur_limited});
            else awaited_results.push_back('{pd, pl});
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_served != hold_ticket) begin
         hold_served = hold_ticket;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Waits until every accepted sample has had its result transferred.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (accepted_count != checked_count) @(posedge clock);
   endtask

   task automatic write_reg(input pidbc_pkg::csr_index_type idx, input logic [31:0] val);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Offers one sample, with a random gap first, and waits for its transfer.
   task automatic offer_sample(input logic [31:0] sp, ms, input bit typed,
                               input logic [31:0] drive, input bit limited);
      csr_we <= 1'b0;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_setpoint <= sp;
      req_measurement <= ms;
      cur_typed <= typed;
      cur_drive <= drive;
      cur_limited <= limited;
      do @(posedge clock); while (!req_ready);
      accepted_count++;
   endtask

   function automatic void cfg_row(pidbc_pkg::csr_index_type idx, logic [31:0] val);
      script.push_back('{1'b1, idx, val, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0});
   endfunction

   function automatic void sample_row(logic [31:0] sp, ms, bit typed = 1'b0,
                                      logic [31:0] drive = 32'd0, bit limited = 1'b0);
      script.push_back('{1'b0, pidbc_pkg::CSR_GAIN_P, 32'd0, sp, ms, typed, drive, limited});
   endfunction

   // Sample values: drifts around an anchor, full range, extremes, moderate.
   function automatic logic [31:0] pick_sample(logic [31:0] anchor);
      int unsigned        pick;
      logic signed [31:0] step;
      pick = $urandom_range(99);
      if (pick < 45) begin
         step = $signed($urandom()) >>> $urandom_range(12, 28);
         return anchor + step;
      end
      if (pick < 65) return $urandom();
      if (pick < 75) begin
         case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      step = $signed($urandom()) >>> $urandom_range(4, 12);
      return step;
   endfunction

   // Register values by phase: ones, then zeros and widest limits, then random.
   function automatic logic [31:0] pick_reg_value(pidbc_pkg::csr_index_type idx, int phase);
      int unsigned pick;
      pick = $urandom_range(99);
      if (phase == 0) return 32'hFFFF_FFFF;
      if (phase == 1) begin
         if (idx == pidbc_pkg::CSR_OUT_MIN) return 32'h8000_0000;
         if (idx == pidbc_pkg::CSR_OUT_MAX) return 32'h7FFF_FFFF;
         return 32'h0;
      end
      case (idx)
         pidbc_pkg::CSR_LPF_ALPHA: begin
            if (pick < 15) return $urandom() & 32'hFFFE_0000;
            if (pick < 30) return 32'h0001_0000;
            if (pick < 45) return ($urandom() & 32'hFFFE_0000) | $urandom_range(65537, 131071);
            return ($urandom() & 32'hFFFE_0000) | $urandom_range(0, 65535);
         end
         pidbc_pkg::CSR_OUT_MIN: begin
            if (pick < 25) return 32'h8000_0000;
            if (pick < 85) return -$urandom_range(0, 32'h00FF_FFFF);
            return $urandom();
         end
         pidbc_pkg::CSR_OUT_MAX: begin
            if (pick < 25) return 32'h7FFF_FFFF;
            if (pick < 85) return $urandom_range(0, 32'h00FF_FFFF);
            return $urandom();
         end
         default: begin
            if (pick < 15) return 32'h0;
            if (pick < 25) return 32'hFFFF_FFFF;
            if (pick < 75) return ($urandom() & 32'hFF00_0000) | $urandom_range(0, 32'h0002_FFFF);
            return $urandom();
         end
      endcase
   endfunction

   // Stimulus and end of run.
   initial begin
      pidbc_pkg::csr_index_type idx;
      logic [31:0]              sp, ms, held_sp, last_ms;
      held_sp = '0;
      last_ms = '0;

      // Zero gains after reset: the drive is the empty integrator.
      sample_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'd0, 1'b0);
      sample_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'd0, 1'b0);
      sample_row(32'h0000_0000, 32'h0000_0000, 1'b1, 32'd0, 1'b0);
      // Inverted limits: below the lower one, then above the upper one.
      cfg_row(pidbc_pkg::CSR_OUT_MIN, 32'd100);
      cfg_row(pidbc_pkg::CSR_OUT_MAX, 32'hFFFF_FF9C);
      sample_row(32'd12345, 32'hFFFF_FCF7, 1'b1, 32'd100, 1'b1);
      cfg_row(pidbc_pkg::CSR_OUT_MIN, 32'hFFFF_FF9C);
      cfg_row(pidbc_pkg::CSR_OUT_MAX, 32'hFFFF_FF38);
      sample_row(32'h0000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_FF38, 1'b1);
      // Moderate gains, alpha written above one.
      cfg_row(pidbc_pkg::CSR_GAIN_P, 32'h0001_0000);
      cfg_row(pidbc_pkg::CSR_GAIN_I_DT, 32'h0000_0800);
      cfg_row(pidbc_pkg::CSR_GAIN_D_OVER_DT, 32'h0002_0000);
      cfg_row(pidbc_pkg::CSR_GAIN_FF, 32'h0000_8000);
      cfg_row(pidbc_pkg::CSR_GAIN_T_DT, 32'h0000_4000);
      cfg_row(pidbc_pkg::CSR_LPF_ALPHA, 32'h0001_FFFF);
      cfg_row(pidbc_pkg::CSR_OUT_MIN, 32'hFFF0_0000);
      cfg_row(pidbc_pkg::CSR_OUT_MAX, 32'h0010_0000);
      sample_row(32'h0001_0000, 32'h0000_0000);
      sample_row(32'h0001_0000, 32'h0000_8000);
      sample_row(32'h0001_0000, 32'h0001_0000);
      sample_row(32'h0005_0000, 32'h0001_0000);
      sample_row(32'h0005_0000, 32'h0003_0000);
      // Alpha of zero: the filtered change holds.
      cfg_row(pidbc_pkg::CSR_LPF_ALPHA, 32'h0000_0000);
      sample_row(32'h0005_0000, 32'h0006_0000);
      sample_row(32'h0005_0000, 32'h0000_0000);
      cfg_row(pidbc_pkg::CSR_LPF_ALPHA, 32'h0000_8000);
      sample_row(32'h0002_0000, 32'h0004_0000);
      sample_row(32'h0002_0000, 32'h0002_0000);
      sample_row(32'h0002_0000, 32'hFFFE_0000);
      // Full gains into a zero window drive the integrator to its bounds.
      cfg_row(pidbc_pkg::CSR_GAIN_P, 32'h00FF_FFFF);
      cfg_row(pidbc_pkg::CSR_GAIN_I_DT, 32'h00FF_FFFF);
      cfg_row(pidbc_pkg::CSR_GAIN_T_DT, 32'h00FF_FFFF);
      cfg_row(pidbc_pkg::CSR_OUT_MIN, 32'h0000_0000);
      cfg_row(pidbc_pkg::CSR_OUT_MAX, 32'h0000_0000);
      sample_row(32'h8000_0000, 32'h7FFF_FFFF);
      sample_row(32'h8000_0000, 32'h7FFF_FFFF);
      sample_row(32'h7FFF_FFFF, 32'h8000_0000);
      sample_row(32'h7FFF_FFFF, 32'h8000_0000);
      cfg_row(pidbc_pkg::CSR_GAIN_D_OVER_DT, 32'h00FF_FFFF);
      cfg_row(pidbc_pkg::CSR_GAIN_FF, 32'h00FF_FFFF);
      cfg_row(pidbc_pkg::CSR_LPF_ALPHA, 32'h0001_0000);
      cfg_row(pidbc_pkg::CSR_OUT_MIN, 32'h8000_0000);
      cfg_row(pidbc_pkg::CSR_OUT_MAX, 32'h7FFF_FFFF);
      sample_row(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      sample_row(32'h8000_0000, 32'h8000_0000);
      sample_row(32'h7FFF_FFFF, 32'h8000_0000);
      sample_row(32'hFFFF_FFFF, 32'h0000_0001);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table, with light idling on both sides.
      send_idle_pct = 24;
      rsp_stall_pct = 24;
      settings_count = 1;
      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            write_reg(script[i].reg_idx, script[i].reg_val);
         end else begin
            offer_sample(script[i].sp, script[i].ms, script[i].typed,
                         script[i].drive, script[i].limited);
         end
      end

      // Random phases, each under a fresh setting of every register.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 68; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 68; end
            default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         idx = idx.first();
         do begin
            write_reg(idx, pick_reg_value(idx, phase));
            idx = idx.next();
         end while (idx != idx.first());
         settings_count++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Back up the result side once so the input side stalls too.
            if (phase == 0 && n == 20) hold_ticket++;
            if ($urandom_range(39) == 0) held_sp = pick_sample(held_sp);
            sp = ($urandom_range(99) < 75) ? held_sp : pick_sample(held_sp);
            ms = pick_sample($urandom_range(1) ? last_ms : sp);
            last_ms = ms;
            offer_sample(sp, ms, 1'b0, 32'd0, 1'b0);
         end
      end

      wait_drained();
      csr_we <= 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         error_count++;
         $error("%0d expected results never arrived", awaited_results.size());
      end
      $display("summary: %0d samples under %0d register settings, %0d results compared",
               accepted_count, settings_count, checked_count);
      $display("summary: %0d results were limited, %0d mismatches", limited_count, error_count);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(RUN_LIMIT_NS);
      $display("tb: errors");
      $finish;
   end

endmodule

FILE: pid_backcalc_antiwindup_core.f
rtl/pidbc_pkg.sv
rtl/pidbc_mul.sv
rtl/pidbc_datapath.sv
rtl/pidbc_ctrl.sv
rtl/pid_backcalc_antiwindup_core.sv
rtl/pidbc_checker.sv
verif/tb.sv
